FILE: rtl/core/hrp_pkg.sv
`timescale 1ns / 1ps
package hrp_pkg;

   // Header size ceiling and counter width
   localparam int MAX_HEADER = 8192;
   localparam int COUNT_W = 13;
   localparam logic [COUNT_W-1:0] LIMIT_CEILING = COUNT_W'(MAX_HEADER - 1);
   localparam logic [COUNT_W-1:0] HEADER_LIMIT_RESET = 13'd8191;

   // Register map
   localparam logic [1:0] ADDR_HEADER_LIMIT = 2'd0;

   // Saturation limits
   localparam logic [15:0] BANK_MAX = 16'hFFFF;
   localparam logic [23:0] CLEN_MAX = 24'hFF_FFFF;

   // Characters
   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_EQ      = 8'h3D;
   localparam logic [7:0] CH_QUEST   = 8'h3F;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_UPPER_P = 8'h50;
   localparam logic [7:0] CH_LOWER_B = 8'h62;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   // Result codes
   localparam logic       ST_PARSED    = 1'b0;
   localparam logic       ST_TOO_LARGE = 1'b1;
   localparam logic [1:0] MTH_GET      = 2'd0;
   localparam logic [1:0] MTH_POST     = 2'd1;
   localparam logic [1:0] MTH_OTHER    = 2'd2;
   localparam logic [3:0] ROUTE_NONE   = 4'd0;

   // Match tables
   localparam int ROUTE_COUNT = 9;
   localparam logic [0:7][7:0] METHOD_TEXT = "GET OST ";
   localparam logic [0:15][7:0] LENGTH_KEY = {"content-length:", CH_SPACE};
   localparam logic [3:0] KEY_LEN = 4'd15;
   localparam logic [0:ROUTE_COUNT-1][0:15][7:0] ROUTE_TEXT = {
      {"/",           {15{CH_SPACE}}},
      {"/logo.bmp",   {7{CH_SPACE}}},
      {"/api/banks",  {6{CH_SPACE}}},
      {"/api/rename", {5{CH_SPACE}}},
      {"/api/delete", {5{CH_SPACE}}},
      {"/api/flash",  {6{CH_SPACE}}},
      {"/api/launch", {5{CH_SPACE}}},
      {"/api/eeprom", {5{CH_SPACE}}},
      {"/api/reset",  {6{CH_SPACE}}}
   };
   localparam logic [0:ROUTE_COUNT-1][3:0] ROUTE_LEN = {
      4'd2, 4'd9, 4'd10, 4'd11, 4'd11, 4'd10, 4'd11, 4'd11, 4'd10
   };

   typedef struct packed {
      logic       new_request;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [1:0]  method;
      logic [3:0]  route;
      logic        bank_present;
      logic [15:0] bank_value;
      logic        length_present;
      logic [23:0] content_length;
      logic [12:0] header_bytes;
   } rsp_type;

   typedef struct packed {
      logic       new_request;
      logic [7:0] data_byte;
      logic [7:0] lower_byte;
      logic       is_digit;
      logic [3:0] digit;
      logic       is_stop;
      logic       is_blank;
      logic       is_cr;
      logic       is_lf;
   } byte_class_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HEADER,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      M_UNDECIDED,
      M_GET,
      M_POST,
      M_UNKNOWN
   } method_code_type;

   typedef enum logic [1:0] {
      Q_SEARCH,
      Q_SAW_B,
      Q_SAW_EQ,
      Q_DIGITS
   } query_state_type;

   typedef enum logic [1:0] {
      L_SEARCH,
      L_SKIP,
      L_DIGITS,
      L_DONE
   } length_state_type;

endpackage

FILE: rtl/core/http_request_header_parser_unit.sv
`timescale 1ns / 1ps
// HTTP request header parser. Feed request bytes through the push/full queue
// port, one byte per item, with new_request set on the first byte of each
// connection; the unit sustains one byte per clock while the output queue has
// room, set by the combinational parser update in the back end. A byte tagged
// by the front end waits in a small input queue (REQ_DEPTH entries), the back
// end consumes one per clock unless it holds, and its summary is written into
// an output queue (RSP_DEPTH entries) at the clock edge at which the back end
// takes the byte. With no back-pressure a result shows on the empty/pop port
// once the back end has taken its last byte. When the output queue is full
// the back end holds, the input queue fills and full rises. At most one
// result follows each request: the parsed summary at the first CR LF CR LF,
// or a too-large error once the byte count reaches header_limit (capped at
// MAX_HEADER-1); a request cut short by the next new_request gives none.
// Bytes after a result, or before any new_request, are dropped. header_limit
// sits at byte address 0 of the APB port; the user must write it only while
// the unit is idle (not enforced). No storage needs clearing after reset.
module http_request_header_parser_unit #(
   parameter int REQ_DEPTH = 4,
   parameter int RSP_DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   // request byte queue
   input  logic             push,
   input  hrp_pkg::req_type req_data,
   output logic             full,
   // result queue
   output logic             empty,
   input  logic             pop,
   output hrp_pkg::rsp_type rsp_data,
   // register port
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [1:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   hrp_pkg::byte_class_type class_item;
   hrp_pkg::byte_class_type queued_item;
   hrp_pkg::rsp_type        result_item;
   logic                    queue_empty;
   logic                    back_ready;
   logic                    result_valid;
   logic                    result_full;
   logic [12:0]             header_limit_ff, header_limit_in;
   logic                    csr_write;

   // Register port: zero-wait, write on the access phase
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready &&
                      (paddr == hrp_pkg::ADDR_HEADER_LIMIT);
   assign header_limit_in = csr_write ? pwdata[12:0] : header_limit_ff;
   assign prdata = (paddr == hrp_pkg::ADDR_HEADER_LIMIT) ? 32'(header_limit_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_limit_ff <= hrp_pkg::HEADER_LIMIT_RESET;
      end else begin
         header_limit_ff <= header_limit_in;
      end
   end

   // Front end: tag each incoming byte with its character classes
   hrp_front u_front (
      .req_data   (req_data),
      .class_item (class_item)
   );

   // Input queue: lets the link keep pushing while the back end stalls
   hrp_fifo #(
      .item_type (hrp_pkg::byte_class_type),
      .DEPTH     (REQ_DEPTH)
   ) u_req_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (class_item),
      .full      (full),
      .pop       (back_ready),
      .pop_item  (queued_item),
      .empty     (queue_empty)
   );

   // Back end: advance the parser one byte per clock, hold when results back up
   hrp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .header_limit (header_limit_ff),
      .in_valid     (!queue_empty),
      .in_item      (queued_item),
      .in_ready     (back_ready),
      .out_ready    (!result_full),
      .out_valid    (result_valid),
      .out_item     (result_item)
   );

   // Output queue: finished results wait here; the parser stalls only when it is full
   hrp_fifo #(
      .item_type (hrp_pkg::rsp_type),
      .DEPTH     (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (result_valid),
      .push_item (result_item),
      .full      (result_full),
      .pop       (pop),
      .pop_item  (rsp_data),
      .empty     (empty)
   );

endmodule

FILE: rtl/core/hrp_front.sv
`timescale 1ns / 1ps
module hrp_front (
   input  hrp_pkg::req_type        req_data,
   output hrp_pkg::byte_class_type class_item
);

   logic [7:0] b;

   assign b = req_data.data_byte;

   // Tag each byte with the character classes the parser tests
   always_comb begin
      class_item.new_request = req_data.new_request;
      class_item.data_byte   = b;
      class_item.lower_byte  = (b inside {[hrp_pkg::CH_UPPER_A:hrp_pkg::CH_UPPER_Z]}) ?
                               b + hrp_pkg::CASE_OFFSET : b;
      class_item.is_digit    = b inside {[hrp_pkg::CH_ZERO:hrp_pkg::CH_NINE]};
      class_item.digit       = 4'(b - hrp_pkg::CH_ZERO);
      class_item.is_stop     = b inside {hrp_pkg::CH_SPACE, hrp_pkg::CH_CR, hrp_pkg::CH_NUL};
      class_item.is_blank    = b inside {hrp_pkg::CH_SPACE, hrp_pkg::CH_TAB};
      class_item.is_cr       = (b == hrp_pkg::CH_CR);
      class_item.is_lf       = (b == hrp_pkg::CH_LF);
   end

endmodule

FILE: rtl/core/hrp_fifo.sv
`timescale 1ns / 1ps
module hrp_fifo #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type             slot_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: rtl/core/hrp_back.sv
`timescale 1ns / 1ps
module hrp_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [12:0]             header_limit,
   input  logic                    in_valid,
   input  hrp_pkg::byte_class_type in_item,
   output logic                    in_ready,
   input  logic                    out_ready,
   output logic                    out_valid,
   output hrp_pkg::rsp_type        out_item
);

   localparam int RC = hrp_pkg::ROUTE_COUNT;

   hrp_pkg::phase_type        phase_ff, phase_in;
   logic [12:0]               count_ff, count_in, cur_count;
   logic [1:0]                term_ff, term_in, cur_term;
   hrp_pkg::method_code_type  method_ff, method_in, cur_method;
   logic [2:0]                mpos_ff, mpos_in, cur_mpos;
   logic [3:0]                ppos_ff, ppos_in, cur_ppos;
   logic [RC-1:0]             cand_ff, cand_in, cur_cand;
   logic                      path_ff, path_in, cur_path;
   hrp_pkg::query_state_type  query_ff, query_in, cur_query;
   logic                      closed_ff, closed_in, cur_closed;
   logic [15:0]               bank_ff, bank_in, cur_bank;
   logic                      line_ff, line_in, cur_line;
   logic [3:0]                key_ff, key_in, cur_key;
   hrp_pkg::length_state_type len_ff, len_in, cur_len;
   logic [23:0]               clen_ff, clen_in, cur_clen;

   logic        take, restart, active, found, too_large, known;
   logic [7:0]  b;
   logic [12:0] eff_limit;
   logic [RC-1:0] path_ok, path_keep, path_full, path_hit;
   logic [19:0] bank_mul;
   logic [15:0] bank_sat;
   logic [27:0] clen_mul;
   logic [23:0] clen_sat;
   logic [3:0]  route_code;

   assign in_ready = out_ready;
   assign take     = in_valid && out_ready;
   assign restart  = take && in_item.new_request;
   assign active   = take && (in_item.new_request || phase_ff == hrp_pkg::PH_HEADER);
   assign b        = in_item.data_byte;

   assign eff_limit = (header_limit > hrp_pkg::LIMIT_CEILING) ?
                      hrp_pkg::LIMIT_CEILING : header_limit;

   // Start from cleared state on the first byte of a request
   always_comb begin
      if (restart) begin
         cur_count  = '0;
         cur_term   = '0;
         cur_method = hrp_pkg::M_UNDECIDED;
         cur_mpos   = '0;
         cur_ppos   = '0;
         cur_cand   = '1;
         cur_path   = 1'b0;
         cur_query  = hrp_pkg::Q_SEARCH;
         cur_closed = 1'b0;
         cur_bank   = '0;
         cur_line   = 1'b1;
         cur_key    = '0;
         cur_len    = hrp_pkg::L_SEARCH;
         cur_clen   = '0;
      end else begin
         cur_count  = count_ff;
         cur_term   = term_ff;
         cur_method = method_ff;
         cur_mpos   = mpos_ff;
         cur_ppos   = ppos_ff;
         cur_cand   = cand_ff;
         cur_path   = path_ff;
         cur_query  = query_ff;
         cur_closed = closed_ff;
         cur_bank   = bank_ff;
         cur_line   = line_ff;
         cur_key    = key_ff;
         cur_len    = len_ff;
         cur_clen   = clen_ff;
      end
   end

   // Route lanes, one compare each
   always_comb begin
      for (int r = 0; r < RC; r++) begin
         if (cur_ppos >= hrp_pkg::ROUTE_LEN[r]) begin
            path_ok[r] = 1'b0;
         end else if (r == 0 && cur_ppos == 4'd1) begin
            path_ok[r] = (b == hrp_pkg::CH_SPACE) || (b == hrp_pkg::CH_QUEST);
         end else begin
            path_ok[r] = (b == hrp_pkg::ROUTE_TEXT[r][cur_ppos]);
         end
      end
      path_keep = cur_cand & path_ok;
      for (int r = 0; r < RC; r++) begin
         path_full[r] = path_keep[r] && (cur_ppos + 4'd1 == hrp_pkg::ROUTE_LEN[r]);
      end
      // lowest completed route wins
      path_hit = path_full & (~path_full + 1'b1);
   end

   // Saturating decimal accumulate
   always_comb begin
      bank_mul = ({4'b0, cur_bank} << 3) + ({4'b0, cur_bank} << 1) + 20'(in_item.digit);
      bank_sat = (bank_mul > 20'(hrp_pkg::BANK_MAX)) ? hrp_pkg::BANK_MAX : bank_mul[15:0];
      clen_mul = ({4'b0, cur_clen} << 3) + ({4'b0, cur_clen} << 1) + 28'(in_item.digit);
      clen_sat = (clen_mul > 28'(hrp_pkg::CLEN_MAX)) ? hrp_pkg::CLEN_MAX : clen_mul[23:0];
   end

   // Parser update for one byte
   always_comb begin
      count_in  = cur_count;
      term_in   = cur_term;
      method_in = cur_method;
      mpos_in   = cur_mpos;
      ppos_in   = cur_ppos;
      cand_in   = cur_cand;
      path_in   = cur_path;
      query_in  = cur_query;
      closed_in = cur_closed;
      bank_in   = cur_bank;
      line_in   = cur_line;
      key_in    = cur_key;
      len_in    = cur_len;
      clen_in   = cur_clen;
      found     = 1'b0;
      if (active) begin
         case (cur_method)
            hrp_pkg::M_UNDECIDED: begin
               if (cur_mpos == 3'd0 && b == hrp_pkg::CH_UPPER_P) begin
                  mpos_in = 3'd4;
               end else if (b != hrp_pkg::METHOD_TEXT[cur_mpos]) begin
                  method_in = hrp_pkg::M_UNKNOWN;
               end else if (cur_mpos == 3'd3 || cur_mpos == 3'd7) begin
                  method_in = (cur_mpos == 3'd3) ? hrp_pkg::M_GET : hrp_pkg::M_POST;
                  path_in   = 1'b1;
                  ppos_in   = '0;
                  cand_in   = '1;
               end else begin
                  mpos_in = cur_mpos + 3'd1;
               end
            end
            hrp_pkg::M_GET, hrp_pkg::M_POST: begin
               if (cur_path) begin
                  if (path_full != '0) begin
                     cand_in = path_hit;
                     path_in = 1'b0;
                  end else begin
                     cand_in = path_keep;
                     if (path_keep == '0) begin
                        path_in = 1'b0;
                     end
                     if (cur_ppos != 4'd15) begin
                        ppos_in = cur_ppos + 4'd1;
                     end
                  end
               end
               if (!cur_closed) begin
                  case (cur_query)
                     hrp_pkg::Q_SEARCH: begin
                        if (in_item.is_stop) begin
                           closed_in = 1'b1;
                        end else if (b == hrp_pkg::CH_LOWER_B) begin
                           query_in = hrp_pkg::Q_SAW_B;
                        end
                     end
                     hrp_pkg::Q_SAW_B: begin
                        if (b == hrp_pkg::CH_EQ) begin
                           query_in = hrp_pkg::Q_SAW_EQ;
                        end else if (in_item.is_stop) begin
                           closed_in = 1'b1;
                        end else if (b != hrp_pkg::CH_LOWER_B) begin
                           query_in = hrp_pkg::Q_SEARCH;
                        end
                     end
                     hrp_pkg::Q_SAW_EQ: begin
                        if (in_item.is_digit) begin
                           query_in = hrp_pkg::Q_DIGITS;
                           bank_in  = 16'(in_item.digit);
                        end else begin
                           closed_in = 1'b1;
                        end
                     end
                     default: begin
                        if (in_item.is_digit) begin
                           bank_in = bank_sat;
                        end else begin
                           closed_in = 1'b1;
                        end
                     end
                  endcase
               end
            end
            default: begin
            end
         endcase

         case (cur_len)
            hrp_pkg::L_SEARCH: begin
               if (cur_line && cur_key != hrp_pkg::KEY_LEN &&
                   in_item.lower_byte == hrp_pkg::LENGTH_KEY[cur_key]) begin
                  key_in = cur_key + 4'd1;
                  if (cur_key == hrp_pkg::KEY_LEN - 4'd1) begin
                     len_in = hrp_pkg::L_SKIP;
                  end
               end else if (in_item.is_lf) begin
                  line_in = 1'b1;
                  key_in  = '0;
               end else begin
                  line_in = 1'b0;
               end
            end
            hrp_pkg::L_SKIP: begin
               if (in_item.is_digit) begin
                  len_in  = hrp_pkg::L_DIGITS;
                  clen_in = 24'(in_item.digit);
               end else if (!in_item.is_blank) begin
                  len_in = hrp_pkg::L_DONE;
               end
            end
            hrp_pkg::L_DIGITS: begin
               if (in_item.is_digit) begin
                  clen_in = clen_sat;
               end else begin
                  len_in = hrp_pkg::L_DONE;
               end
            end
            default: begin
            end
         endcase

         if (in_item.is_cr) begin
            term_in = (cur_term == 2'd2) ? 2'd3 : 2'd1;
         end else if (in_item.is_lf) begin
            found   = (cur_term == 2'd3);
            term_in = (cur_term == 2'd1) ? 2'd2 : 2'd0;
         end else begin
            term_in = 2'd0;
         end

         count_in = cur_count + 13'd1;
      end
   end

   assign too_large = (count_in >= eff_limit);

   // Phase: next state
   always_comb begin
      phase_in = phase_ff;
      if (active && (found || too_large)) begin
         phase_in = hrp_pkg::PH_DONE;
      end else if (restart) begin
         phase_in = hrp_pkg::PH_HEADER;
      end
   end

   // Phase: result output
   always_comb begin
      known      = (method_in == hrp_pkg::M_GET) || (method_in == hrp_pkg::M_POST);
      route_code = hrp_pkg::ROUTE_NONE;
      for (int r = RC - 1; r >= 0; r--) begin
         if (cand_in[r]) begin
            route_code = 4'(r + 1);
         end
      end
      out_valid = active && (found || too_large);
      out_item  = '0;
      out_item.header_bytes = count_in;
      if (found) begin
         out_item.status = hrp_pkg::ST_PARSED;
         if (!known) begin
            out_item.method = hrp_pkg::MTH_OTHER;
         end else if (method_in == hrp_pkg::M_GET) begin
            out_item.method = hrp_pkg::MTH_GET;
         end else begin
            out_item.method = hrp_pkg::MTH_POST;
         end
         if (known && !path_in) begin
            out_item.route = route_code;
         end
         if (known && query_in == hrp_pkg::Q_DIGITS) begin
            out_item.bank_present = 1'b1;
            out_item.bank_value   = bank_in;
         end
         if (method_in == hrp_pkg::M_POST && len_in != hrp_pkg::L_SEARCH) begin
            out_item.length_present = 1'b1;
            out_item.content_length = clen_in;
         end
      end else begin
         out_item.status = hrp_pkg::ST_TOO_LARGE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= hrp_pkg::PH_IDLE;
         count_ff  <= '0;
         term_ff   <= '0;
         method_ff <= hrp_pkg::M_UNDECIDED;
         mpos_ff   <= '0;
         ppos_ff   <= '0;
         cand_ff   <= '1;
         path_ff   <= 1'b0;
         query_ff  <= hrp_pkg::Q_SEARCH;
         closed_ff <= 1'b0;
         bank_ff   <= '0;
         line_ff   <= 1'b1;
         key_ff    <= '0;
         len_ff    <= hrp_pkg::L_SEARCH;
         clen_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         term_ff   <= term_in;
         method_ff <= method_in;
         mpos_ff   <= mpos_in;
         ppos_ff   <= ppos_in;
         cand_ff   <= cand_in;
         path_ff   <= path_in;
         query_ff  <= query_in;
         closed_ff <= closed_in;
         bank_ff   <= bank_in;
         line_ff   <= line_in;
         key_ff    <= key_in;
         len_ff    <= len_in;
         clen_ff   <= clen_in;
      end
   end

endmodule

FILE: rtl/core/hrp_checker.sv
`timescale 1ns / 1ps
module hrp_checker (
   input logic             clock,
   input logic             reset,
   input logic             full,
   input logic             empty,
   input logic             pop,
   input hrp_pkg::rsp_type rsp_data,
   input logic             psel,
   input logic             penable,
   input logic             pwrite,
   input logic [1:0]       paddr,
   input logic [31:0]      pwdata,
   input logic [31:0]      prdata,
   input logic             pready
);

   // Both queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty && !full)
      else $error("queues not empty after reset");

   // A waiting result holds until popped
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_data))
      else $error("waiting result changed before pop");

   // Error results carry only the byte count
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_data.status == hrp_pkg::ST_TOO_LARGE |->
         rsp_data.method == '0 && rsp_data.route == hrp_pkg::ROUTE_NONE &&
         !rsp_data.bank_present && !rsp_data.length_present &&
         rsp_data.bank_value == '0 && rsp_data.content_length == '0)
      else $error("error result with parsed fields set");

   // Unknown method reports nothing; length only for POST
   a_method_fields: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_data.status == hrp_pkg::ST_PARSED |->
         (rsp_data.method != hrp_pkg::MTH_OTHER ||
          (rsp_data.route == hrp_pkg::ROUTE_NONE && !rsp_data.bank_present)) &&
         (!rsp_data.length_present || rsp_data.method == hrp_pkg::MTH_POST))
      else $error("result fields inconsistent with method");

   // A limit write reads back on the next cycle
   a_limit_readback: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && pready && paddr == hrp_pkg::ADDR_HEADER_LIMIT |=>
         paddr != hrp_pkg::ADDR_HEADER_LIMIT || prdata[12:0] == $past(pwdata[12:0]))
      else $error("header_limit readback mismatch");

endmodule

bind http_request_header_parser_unit hrp_checker u_checker (.*);
